@@ src/espd_pkg.sv @@
// Shared types and constants of the encoder speed PID drive block.
// Used by espd_cfg, espd_ctrl, espd_dp and encoder_speed_pid_drive_core.
// Depends on nothing.
package espd_pkg;

    // Fixed-point format and encoder width.
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_WIDTH = 32;

    // Word widths.
    localparam int Q_W    = 32;                 // signed Q value
    localparam int GAIN_W = 31;                 // unsigned Q registers
    localparam int MUL_W  = Q_W + 1;            // shared multiplier operand
    localparam int PROD_W = 2 * MUL_W;          // multiplier product
    localparam int QP_W   = PROD_W - FRAC_BITS; // rounded Q product
    localparam int SUM_W  = QP_W + 2;           // sum of three PID terms
    localparam int ACC_W  = Q_W + 4;            // FIR weighted sum

    // Constant divide by ten, several quotient bits per cycle.
    localparam int FIR_DIV       = 10;
    localparam int FIR_HALF      = FIR_DIV / 2;
    localparam int DIV_STEP_BITS = 6;
    localparam int DIV_STEPS     = ACC_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W         = $clog2(FIR_DIV);

    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int DUTY_W     = 8;
    localparam int DUTY_LSB   = 2 * FRAC_BITS;

    // Stream payload widths.
    localparam int IN_W         = 2 * Q_W;
    localparam int OUT_FIELDS_W = DUTY_W + 2 + Q_W + Q_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        SPIN_RELEASE,
        SPIN_FORWARD,
        SPIN_BACKWARD,
        SPIN_KEEP
    } spin_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_SCALE,
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN,
        CFG_DERIV_GAIN,
        CFG_INTEGRAL_STEP,
        CFG_UPPER_LIMIT,
        CFG_LOWER_LIMIT,
        CFG_DUTY_SCALE
    } cfg_idx_t;

    typedef struct packed {
        logic signed [Q_W-1:0]  speed_scale;
        logic signed [Q_W-1:0]  prop_gain;
        logic signed [Q_W-1:0]  integ_gain;
        logic signed [Q_W-1:0]  deriv_gain;
        logic [GAIN_W-1:0]      integral_step;
        logic signed [Q_W-1:0]  upper_limit;
        logic signed [Q_W-1:0]  lower_limit;
        logic [GAIN_W-1:0]      duty_scale;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        speed_scale:   '0,
        prop_gain:     '0,
        integ_gain:    '0,
        deriv_gain:    '0,
        integral_step: GAIN_W'((1 << FRAC_BITS) / 100),
        upper_limit:   Q_W'(255 << FRAC_BITS),
        lower_limit:   Q_W'(-(255 << FRAC_BITS)),
        duty_scale:    GAIN_W'(1 << FRAC_BITS)
    };

    // Datapath commands, one per controller step.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL_SPEED,
        OP_FIR,
        OP_DIV,
        OP_ERR,
        OP_MUL_INTEG,
        OP_INTEG,
        OP_PROP,
        OP_INTEG_TERM,
        OP_DERIV,
        OP_CLAMP,
        OP_MUL_DUTY,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SPEED,
        S_FIR,
        S_DIV,
        S_ERR,
        S_MUL_INTEG,
        S_INTEG,
        S_PROP,
        S_INTEG_TERM,
        S_DERIV,
        S_CLAMP,
        S_MUL_DUTY,
        S_DONE
    } state_t;

endpackage

@@ src/espd_cfg.sv @@
// Configuration register file of the encoder speed PID drive block.
// Depends on espd_pkg for the register index codes and the cfg_t layout.
module espd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [espd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [espd_pkg::Q_W-1:0]        cfg_data,
    output espd_pkg::cfg_t                  cfg
);
    import espd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPEED_SCALE:   cfg_next.speed_scale   = cfg_data;
                CFG_PROP_GAIN:     cfg_next.prop_gain     = cfg_data;
                CFG_INTEG_GAIN:    cfg_next.integ_gain    = cfg_data;
                CFG_DERIV_GAIN:    cfg_next.deriv_gain    = cfg_data;
                CFG_INTEGRAL_STEP: cfg_next.integral_step = cfg_data[GAIN_W-1:0];
                CFG_UPPER_LIMIT:   cfg_next.upper_limit   = cfg_data;
                CFG_LOWER_LIMIT:   cfg_next.lower_limit   = cfg_data;
                CFG_DUTY_SCALE:    cfg_next.duty_scale    = cfg_data[GAIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/espd_ctrl.sv @@
// Sequencer of the encoder speed PID drive block: steps one item through the
// datapath and owns the input and output handshakes. Depends on espd_pkg.
module espd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output espd_pkg::dp_op_t cmd
);
    import espd_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] step_cnt_reg;
    logic [DIV_CNT_W-1:0] step_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        cmd            = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = OP_LOAD;
                    state_next = S_MUL_SPEED;
                end
            end
            S_MUL_SPEED:
            begin
                cmd        = OP_MUL_SPEED;
                state_next = S_FIR;
            end
            S_FIR:
            begin
                cmd           = OP_FIR;
                step_cnt_next = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd = OP_DIV;
                if (step_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            S_ERR:
            begin
                cmd        = OP_ERR;
                state_next = S_MUL_INTEG;
            end
            S_MUL_INTEG:
            begin
                cmd        = OP_MUL_INTEG;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                cmd        = OP_INTEG;
                state_next = S_PROP;
            end
            S_PROP:
            begin
                cmd        = OP_PROP;
                state_next = S_INTEG_TERM;
            end
            S_INTEG_TERM:
            begin
                cmd        = OP_INTEG_TERM;
                state_next = S_DERIV;
            end
            S_DERIV:
            begin
                cmd        = OP_DERIV;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd        = OP_CLAMP;
                state_next = S_MUL_DUTY;
            end
            S_MUL_DUTY:
            begin
                cmd        = OP_MUL_DUTY;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // The result register is free, or is being emptied this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/espd_dp.sv @@
// Datapath of the encoder speed PID drive block: one shared multiplier, the
// divide-by-ten unit, the filter and PID state and the result register.
// Depends on espd_pkg; driven by commands from espd_ctrl.
module espd_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  espd_pkg::dp_op_t             cmd,
    input  espd_pkg::cfg_t               cfg,
    input  logic [espd_pkg::IN_W-1:0]    in_data,
    output logic [espd_pkg::OUT_W-1:0]   out_data
);
    import espd_pkg::*;

    // Saturate a wide signed value to one Q word.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic same;
        same  = (&v[PROD_W-1:Q_W-1]) | ~(|v[PROD_W-1:Q_W-1]);
        sat_q = same ? v[Q_W-1:0]
                     : (v[PROD_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}});
    endfunction

    // Filter and PID state, cleared by reset.
    logic [COUNT_WIDTH-1:0] last_count_reg, last_count_next;
    logic signed [Q_W-1:0]  hist0_reg, hist0_next;
    logic signed [Q_W-1:0]  hist1_reg, hist1_next;
    logic signed [Q_W-1:0]  hist2_reg, hist2_next;
    logic signed [Q_W-1:0]  integ_acc_reg, integ_acc_next;
    logic signed [Q_W-1:0]  prev_err_reg, prev_err_next;

    // Working registers of the item in flight.
    logic signed [Q_W-1:0]    target_reg, target_next;
    logic signed [Q_W-1:0]    delta_reg, delta_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]         div_reg, div_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic signed [Q_W-1:0]    filt_reg, filt_next;
    logic signed [Q_W-1:0]    err_reg, err_next;
    logic signed [Q_W-1:0]    dk_reg, dk_next;
    logic signed [Q_W-1:0]    ik_reg, ik_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [Q_W-1:0]    drive_reg, drive_next;
    logic [OUT_W-1:0]         out_reg, out_next;

    // Shared multiplier and rounding of its product.
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_en;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0]        prod_rnd;
    logic signed [QP_W-1:0]   qterm;

    assign mul_p    = mul_a * mul_b;
    assign prod_rnd = prod_reg + PROD_W'(ROUND_HALF);
    assign qterm    = prod_rnd[PROD_W-1:FRAC_BITS];
    assign out_data = out_reg;

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd)
            OP_MUL_SPEED:
            begin
                mul_a = MUL_W'(delta_reg);
                mul_b = MUL_W'(cfg.speed_scale);
            end
            OP_MUL_INTEG:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'({1'b0, cfg.integral_step});
            end
            OP_INTEG:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(cfg.prop_gain);
            end
            OP_PROP:
            begin
                mul_a = MUL_W'(ik_reg);
                mul_b = MUL_W'(cfg.integ_gain);
            end
            OP_INTEG_TERM:
            begin
                mul_a = MUL_W'(dk_reg);
                mul_b = MUL_W'(cfg.deriv_gain);
            end
            OP_MUL_DUTY:
            begin
                // Magnitude of the drive; the most negative word needs the extra bit.
                mul_a = drive_reg[Q_W-1] ? -MUL_W'(drive_reg) : MUL_W'(drive_reg);
                mul_b = MUL_W'({1'b0, cfg.duty_scale});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        logic [COUNT_WIDTH-1:0]  count;
        logic [COUNT_WIDTH-1:0]  dwrap;
        logic signed [Q_W-1:0]   s0;
        logic signed [Q_W:0]     pair_new;
        logic signed [Q_W:0]     pair_old;
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-1:0]        d;
        logic [REM_W:0]          r;
        logic signed [Q_W:0]     quot;
        logic signed [Q_W:0]     filt_w;
        logic signed [QP_W:0]    isum;
        logic signed [Q_W-1:0]   ik_s;
        logic [DUTY_W-1:0]       duty;
        spin_t                   spin;

        last_count_next = last_count_reg;
        hist0_next      = hist0_reg;
        hist1_next      = hist1_reg;
        hist2_next      = hist2_reg;
        integ_acc_next  = integ_acc_reg;
        prev_err_next   = prev_err_reg;
        target_next     = target_reg;
        delta_next      = delta_reg;
        prod_next       = mul_en ? mul_p : prod_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        filt_next       = filt_reg;
        err_next        = err_reg;
        dk_next         = dk_reg;
        ik_next         = ik_reg;
        sum_next        = sum_reg;
        drive_next      = drive_reg;
        out_next        = out_reg;

        count    = in_data[COUNT_WIDTH-1:0];
        dwrap    = count - last_count_reg;
        s0       = sat_q(prod_reg);
        pair_new = (Q_W + 1)'(s0) + (Q_W + 1)'(hist0_reg);
        pair_old = (Q_W + 1)'(hist1_reg) + (Q_W + 1)'(hist2_reg);
        acc      = (ACC_W'(pair_new) <<< 1) + ACC_W'(pair_old) + (ACC_W'(pair_old) <<< 1);

        // Six restoring steps of the divide by ten; the remainder stays below ten.
        d = div_reg;
        r = {1'b0, rem_reg};
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            r = {r[REM_W-1:0], d[ACC_W-1]};
            d = {d[ACC_W-2:0], 1'b0};
            if (r >= (REM_W + 1)'(FIR_DIV))
            begin
                r    = r - (REM_W + 1)'(FIR_DIV);
                d[0] = 1'b1;
            end
        end

        quot   = $signed({1'b0, div_reg[Q_W-1:0]});
        filt_w = neg_reg ? -quot : quot;
        isum   = (QP_W + 1)'(qterm) + (QP_W + 1)'(integ_acc_reg);
        ik_s   = sat_q(PROD_W'(isum));

        if (|prod_reg[PROD_W-1:DUTY_LSB+DUTY_W])
        begin
            duty = '1;
        end
        else
        begin
            duty = prod_reg[DUTY_LSB+DUTY_W-1:DUTY_LSB];
        end

        if (target_reg == '0)
        begin
            spin = SPIN_RELEASE;
            duty = '0;
        end
        else if (drive_reg > 0)
        begin
            spin = SPIN_FORWARD;
        end
        else if (drive_reg < 0)
        begin
            spin = SPIN_BACKWARD;
        end
        else
        begin
            spin = SPIN_KEEP;
        end

        case (cmd)
            OP_LOAD:
            begin
                target_next     = in_data[IN_W-1:Q_W];
                delta_next      = Q_W'($signed(dwrap));
                last_count_next = count;
            end
            OP_FIR:
            begin
                hist0_next = s0;
                hist1_next = hist0_reg;
                hist2_next = hist1_reg;
                neg_next   = acc[ACC_W-1];
                div_next   = (acc[ACC_W-1] ? -acc : acc) + ACC_W'(FIR_HALF);
                rem_next   = '0;
            end
            OP_DIV:
            begin
                div_next = d;
                rem_next = r[REM_W-1:0];
            end
            OP_ERR:
            begin
                filt_next = filt_w[Q_W-1:0];
                err_next  = sat_q(PROD_W'((Q_W + 1)'(target_reg) - filt_w));
            end
            OP_MUL_INTEG:
            begin
                dk_next       = sat_q(PROD_W'((Q_W + 1)'(err_reg) - (Q_W + 1)'(prev_err_reg)));
                prev_err_next = err_reg;
            end
            OP_INTEG:
            begin
                if (ik_s > cfg.upper_limit)
                begin
                    ik_next = cfg.upper_limit;
                end
                else if (ik_s < cfg.lower_limit)
                begin
                    ik_next = cfg.lower_limit;
                end
                else
                begin
                    ik_next = ik_s;
                end
            end
            OP_PROP:
            begin
                sum_next = SUM_W'(qterm);
            end
            OP_INTEG_TERM, OP_DERIV:
            begin
                sum_next = sum_reg + SUM_W'(qterm);
            end
            OP_CLAMP:
            begin
                if (sum_reg < SUM_W'(cfg.lower_limit))
                begin
                    drive_next = cfg.lower_limit;
                end
                else if (sum_reg > SUM_W'(cfg.upper_limit))
                begin
                    drive_next = cfg.upper_limit;
                end
                else
                begin
                    drive_next = sum_reg[Q_W-1:0];
                end
                integ_acc_next = (target_reg == '0) ? '0 : ik_reg;
            end
            OP_RESULT:
            begin
                out_next = OUT_W'({filt_reg, drive_reg, spin, duty});
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            hist0_reg      <= '0;
            hist1_reg      <= '0;
            hist2_reg      <= '0;
            integ_acc_reg  <= '0;
            prev_err_reg   <= '0;
        end
        else
        begin
            last_count_reg <= last_count_next;
            hist0_reg      <= hist0_next;
            hist1_reg      <= hist1_next;
            hist2_reg      <= hist2_next;
            integ_acc_reg  <= integ_acc_next;
            prev_err_reg   <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        delta_reg  <= delta_next;
        prod_reg   <= prod_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        filt_reg   <= filt_next;
        err_reg    <= err_next;
        dk_reg     <= dk_next;
        ik_reg     <= ik_next;
        sum_reg    <= sum_next;
        drive_reg  <= drive_next;
        out_reg    <= out_next;
    end

endmodule

@@ src/encoder_speed_pid_drive_core.sv @@
// Top level of the encoder speed PID drive block.
// Depends on espd_pkg, espd_cfg, espd_ctrl and espd_dp.
//
// Usage: once per control period the host sends one request on the slave
// stream holding the encoder position and the target speed. The block forms
// the raw speed from the wrapped count delta, smooths it with a four-tap FIR,
// runs a PID loop on the speed error and returns one result request with the
// PWM duty, the direction command, the clamped drive and the filtered speed.
// A zero target speed releases the motor and clears the integral.
//
// The gains, limits and scales are written on the configuration channel,
// which is always ready; write it only while no request is in flight.
//
// The sequencer steps each item through one shared 33x33 multiplier and a
// divide-by-ten unit that retires six quotient bits a cycle, and takes the
// next request only once the item in flight has handed over its result.
// While a result waits for m_axis_tready the next item is already accepted
// and computed; it then holds in its last step until the output register is
// free. Reset clears the filter history, the integral, the last count and
// the previous error, and restores the register defaults (gain 0, period
// 0.01 s, limits +/-255.0, duty scale 1.0).
module encoder_speed_pid_drive_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] encoder_count, [63:32] target_speed
    input  logic [espd_pkg::IN_W-1:0]       s_axis_tdata,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] pwm_duty, [9:8] spin_command, [41:10] drive_value,
    // [73:42] filtered_speed, [79:74] zero
    output logic [espd_pkg::OUT_W-1:0]      m_axis_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [espd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [espd_pkg::Q_W-1:0]        cfg_data
);
    import espd_pkg::*;

    cfg_t   cfg;
    dp_op_t cmd;

    espd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The sequencer owns both handshakes and issues one command per cycle.
    espd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // The datapath holds the filter and PID state and the result register.
    espd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

@@ tb/espd_drive_checker.sv @@
// Checker for the encoder speed PID drive block: watches the configuration,
// input and result channels, predicts every result and compares it.
// Depends on espd_pkg.
module espd_drive_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [espd_pkg::IN_W-1:0]      s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [espd_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [espd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [espd_pkg::Q_W-1:0]       cfg_data,
    input  logic                           final_check,
    output int                             errors,
    output int                             pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import espd_pkg::*;

    localparam int     SPIN_LSB  = DUTY_W;
    localparam int     DRIVE_LSB = SPIN_LSB + 2;
    localparam int     SPEED_LSB = DRIVE_LSB + Q_W;
    localparam int     PAD_LSB   = SPEED_LSB + Q_W;
    localparam longint DUTY_MAX  = (1 << DUTY_W) - 1;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam int     PRINT_CAP = 40;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        spin_t             spin;
        logic [Q_W-1:0]    drive;
        logic [Q_W-1:0]    speed;
    } drive_result_t;

    // Register copies.
    logic signed [Q_W-1:0] speed_scale, prop_gain, integ_gain, deriv_gain;
    logic signed [Q_W-1:0] upper_limit, lower_limit;
    logic [GAIN_W-1:0]     integral_step, duty_scale;

    // Controller state.
    logic [Q_W-1:0]        last_count;
    logic signed [Q_W-1:0] speed_hist [3];
    logic signed [Q_W-1:0] integ_acc;
    logic signed [Q_W-1:0] prev_error;

    drive_result_t expected_drive_q [$];

    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Q product rounded to nearest, ties toward plus infinity.
    function automatic longint q_product(input longint a, input longint b);
        return (a * b + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < PRINT_CAP)
            $display("[%0t] drive check: %s", $time, what);
        errors++;
    endtask

    task automatic store_setting(input cfg_idx_t idx, input logic [Q_W-1:0] value);
        case (idx)
            CFG_SPEED_SCALE:   speed_scale   = value;
            CFG_PROP_GAIN:     prop_gain     = value;
            CFG_INTEG_GAIN:    integ_gain    = value;
            CFG_DERIV_GAIN:    deriv_gain    = value;
            CFG_INTEGRAL_STEP: integral_step = value[GAIN_W-1:0];
            CFG_UPPER_LIMIT:   upper_limit   = value;
            CFG_LOWER_LIMIT:   lower_limit   = value;
            CFG_DUTY_SCALE:    duty_scale    = value[GAIN_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic predict_drive(input logic [IN_W-1:0] req);
        logic [Q_W-1:0] count_now, delta_w;
        longint         target, raw, acc, speed, rem, err, integ, diff, drive, mag, duty;
        drive_result_t  want;
        count_now  = req[Q_W-1:0];
        target     = longint'($signed(req[IN_W-1:Q_W]));
        delta_w    = count_now - last_count;
        last_count = count_now;
        raw = clamp_q(longint'($signed(delta_w)) * longint'(speed_scale));

        // FIR, newest sample first, weights 0.2 0.2 0.3 0.3; the quotient
        // truncates and the remainder rounds it away from zero.
        acc = 2 * (raw + longint'(speed_hist[0]))
            + 3 * (longint'(speed_hist[1]) + longint'(speed_hist[2]));
        speed = acc / FIR_DIV;
        rem   = acc % FIR_DIV;
        if (rem >= FIR_HALF)
            speed++;
        else if (rem <= -FIR_HALF)
            speed--;
        speed_hist[2] = speed_hist[1];
        speed_hist[1] = speed_hist[0];
        speed_hist[0] = raw[Q_W-1:0];

        err   = clamp_q(target - speed);
        integ = clamp_q(q_product(err, longint'(integral_step)) + longint'(integ_acc));
        if (integ > longint'(upper_limit))
            integ = longint'(upper_limit);
        else if (integ < longint'(lower_limit))
            integ = longint'(lower_limit);
        diff  = clamp_q(err - longint'(prev_error));
        drive = q_product(err, longint'(prop_gain)) + q_product(integ, longint'(integ_gain))
              + q_product(diff, longint'(deriv_gain));
        // Lower bound is checked first; this matters when the limits are inverted.
        if (drive < longint'(lower_limit))
            drive = longint'(lower_limit);
        else if (drive > longint'(upper_limit))
            drive = longint'(upper_limit);
        integ_acc  = integ[Q_W-1:0];
        prev_error = err[Q_W-1:0];

        mag  = (drive < 0) ? -drive : drive;
        duty = (mag * longint'(duty_scale)) >>> DUTY_LSB;
        if (duty > DUTY_MAX)
            duty = DUTY_MAX;

        if (target == 0)
        begin
            want.spin = SPIN_RELEASE;
            duty      = 0;
            integ_acc = '0;
        end
        else if (drive > 0)
        begin
            want.spin = SPIN_FORWARD;
        end
        else if (drive < 0)
        begin
            want.spin = SPIN_BACKWARD;
        end
        else
        begin
            want.spin = SPIN_KEEP;
        end
        want.duty  = duty[DUTY_W-1:0];
        want.drive = drive[Q_W-1:0];
        want.speed = speed[Q_W-1:0];
        expected_drive_q.push_back(want);
    endtask

    task automatic check_result(input logic [OUT_W-1:0] got);
        drive_result_t want;
        if (expected_drive_q.size() == 0)
        begin
            report_mismatch($sformatf("result %h with no request waiting", got));
            return;
        end
        want = expected_drive_q.pop_front();
        if (got[SPIN_LSB-1:0] !== want.duty)
            report_mismatch($sformatf("pwm_duty got %0d expected %0d",
                got[SPIN_LSB-1:0], want.duty));
        if (got[DRIVE_LSB-1:SPIN_LSB] !== want.spin)
            report_mismatch($sformatf("spin_command got %0d expected %s",
                got[DRIVE_LSB-1:SPIN_LSB], want.spin.name()));
        if (got[SPEED_LSB-1:DRIVE_LSB] !== want.drive)
            report_mismatch($sformatf("drive_value got %0d expected %0d",
                $signed(got[SPEED_LSB-1:DRIVE_LSB]), $signed(want.drive)));
        if (got[PAD_LSB-1:SPEED_LSB] !== want.speed)
            report_mismatch($sformatf("filtered_speed got %0d expected %0d",
                $signed(got[PAD_LSB-1:SPEED_LSB]), $signed(want.speed)));
        if (got[OUT_W-1:PAD_LSB] !== '0)
            report_mismatch($sformatf("padding bits not zero: %h", got[OUT_W-1:PAD_LSB]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale   = CFG_RESET.speed_scale;
            prop_gain     = CFG_RESET.prop_gain;
            integ_gain    = CFG_RESET.integ_gain;
            deriv_gain    = CFG_RESET.deriv_gain;
            integral_step = CFG_RESET.integral_step;
            upper_limit   = CFG_RESET.upper_limit;
            lower_limit   = CFG_RESET.lower_limit;
            duty_scale    = CFG_RESET.duty_scale;
            last_count    = '0;
            speed_hist    = '{default: '0};
            integ_acc     = '0;
            prev_error    = '0;
            errors        = 0;
            expected_drive_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                store_setting(cfg_idx_t'(cfg_index), cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                predict_drive(s_axis_tdata);
            if (final_check && expected_drive_q.size() != 0)
            begin
                report_mismatch($sformatf("%0d expected results never arrived",
                    expected_drive_q.size()));
                expected_drive_q.delete();
            end
            pending <= expected_drive_q.size();
        end
    end

endmodule

@@ tb/encoder_speed_pid_drive_core_tb.sv @@
// Top of the testbench for encoder_speed_pid_drive_core: clock, reset,
// configuration phases, input requests, result back-pressure and verdict.
// Depends on espd_pkg, the block itself and espd_drive_checker.
module encoder_speed_pid_drive_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import espd_pkg::*;

    localparam int ONE         = 1 << FRAC_BITS;  // 1.0 in Q format
    localparam int LONG_HOLD   = 300;             // receiver hold-off, cycles
    localparam int DRAIN_LIMIT = 2000;            // cycles allowed to drain results
    localparam int SETTLE      = 40;              // well above one item's latency
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 54;

    // One full set of register values, in register index order.
    typedef struct {
        logic [Q_W-1:0] scale;
        logic [Q_W-1:0] kp;
        logic [Q_W-1:0] ki;
        logic [Q_W-1:0] kd;
        logic [Q_W-1:0] step;
        logic [Q_W-1:0] upper;
        logic [Q_W-1:0] lower;
        logic [Q_W-1:0] duty;
    } drive_settings_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [Q_W-1:0]       cfg_data      = '0;
    logic                 final_check   = 1'b0;
    int                   mismatch_count;
    int                   results_pending;

    // The stimulus asks the receiver for a long hold-off by bumping
    // hold_requests; the receiver counts the ones it has served.
    int                   hold_requests = 0;
    int                   holds_served  = 0;

    // Sender pacing: requests go out in bursts with idle gaps between them.
    int                   burst_left    = 0;
    bit                   gapless       = 1'b0;

    encoder_speed_pid_drive_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    espd_drive_checker drive_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .final_check   (final_check),
        .errors        (mismatch_count),
        .pending       (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run, with a wide margin over the slowest correct run.
    initial begin
        #(2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side. The receiver changes its stall pattern at random intervals:
    // always ready, coin flip, a fixed one-in-four stall, or mostly
    // stalled. A long hold-off requested by the stimulus takes priority and
    // is timed here, so the block fills up and stops taking input while the
    // sender keeps offering.
    initial begin : result_sink
        int mode;
        int span;
        int tick;
        span = 0;
        tick = 0;
        mode = 0;
        wait (rst_n);
        forever begin
            if (hold_requests != holds_served) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 120);
                end
                span--;
                tick++;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    2:       m_axis_tready <= (tick % 4) != 3;
                    default: m_axis_tready <= $urandom_range(0, 3) == 0;
                endcase
                @(posedge clk);
            end
        end
    end

    // Holds one configuration write until the channel takes it. The caller
    // lowers cfg_valid after the last write of a group.
    task automatic write_register(input cfg_idx_t idx, input logic [Q_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings(input drive_settings_t s);
        write_register(CFG_SPEED_SCALE,   s.scale);
        write_register(CFG_PROP_GAIN,     s.kp);
        write_register(CFG_INTEG_GAIN,    s.ki);
        write_register(CFG_DERIV_GAIN,    s.kd);
        write_register(CFG_INTEGRAL_STEP, s.step);
        write_register(CFG_UPPER_LIMIT,   s.upper);
        write_register(CFG_LOWER_LIMIT,   s.lower);
        write_register(CFG_DUTY_SCALE,    s.duty);
        cfg_valid <= 1'b0;
    endtask

    // Offers one speed request and returns at the edge where it is taken.
    // tvalid stays high into the next request of the same burst; it drops
    // when a gap starts or when wait_for_drain stops sending.
    task automatic send_speed_request(input logic [Q_W-1:0] count,
                                      input logic [Q_W-1:0] target);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gapless ? 0 : $urandom_range(0, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {target, count};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result has been taken,
    // then lets the block settle. The first edge is waited unconditionally
    // because the checker's pending count is registered and lags the last request.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge clk);
            waited++;
        end while (results_pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Signed Q value: half the time within +/- whole, else an extreme, zero or raw bits.
    function automatic logic [Q_W-1:0] pick_signed_q(input int whole);
        int span;
        span = whole * ONE;
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return $urandom;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // Unsigned register value. Raw random bits can also set bit 31, which the
    // block must drop for these 31-bit registers.
    function automatic logic [Q_W-1:0] pick_unsigned_q(input int whole);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, whole * ONE);
        endcase
    endfunction

    function automatic drive_settings_t pick_settings();
        drive_settings_t s;
        int              bound;
        s.scale = pick_signed_q(4);
        s.kp    = pick_signed_q(8);
        s.ki    = pick_signed_q(8);
        s.kd    = pick_signed_q(8);
        s.step  = pick_unsigned_q(1);
        s.duty  = pick_unsigned_q(4);
        bound   = $urandom_range(1, 1000 * ONE);
        case ($urandom_range(0, 7))
            0: begin
                s.upper = 32'h7FFF_FFFF;
                s.lower = 32'h8000_0000;
            end
            1: begin
                // Inverted limits: lower above upper.
                s.upper = -bound;
                s.lower = bound;
            end
            2: begin
                s.upper = $urandom;
                s.lower = $urandom;
            end
            default: begin
                s.upper = bound;
                s.lower = -$urandom_range(1, 1000 * ONE);
            end
        endcase
        return s;
    endfunction

    initial begin : stimulus
        drive_settings_t nominal;
        drive_settings_t s;
        logic [Q_W-1:0]  enc_count;
        logic [Q_W-1:0]  set_point;
        logic [Q_W-1:0]  count;
        logic [Q_W-1:0]  target;

        nominal = '{32'(ONE), 32'(2 * ONE), 32'(ONE / 2), 32'(ONE / 4),
                    32'(655), 32'(255 * ONE), -32'(255 * ONE), 32'(ONE)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset defaults: all gains are zero, so the drive is zero and a
        // nonzero target gives the keep-direction command with zero duty.
        send_speed_request(32'd5, 32'(ONE));
        send_speed_request(32'd9, -32'(ONE));
        send_speed_request(32'd9, 32'd0);
        wait_for_drain();

        // A plain controller, then the count and target extremes: a huge
        // positive delta, wraps across the sign boundary, the most negative
        // delta, release in the middle of a run, and the extreme targets.
        apply_settings(nominal);
        send_speed_request(32'd100, 32'(10 * ONE));
        send_speed_request(32'd200, 32'(10 * ONE));
        send_speed_request(32'd150, -32'(20 * ONE));
        send_speed_request(32'd150, 32'd0);
        send_speed_request(32'h7FFF_FFFF, 32'(50 * ONE));
        send_speed_request(32'h8000_0000, 32'(50 * ONE));
        send_speed_request(32'h0000_0000, 32'(50 * ONE));
        send_speed_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_speed_request(32'hFFFF_FFFF, 32'h8000_0000);
        send_speed_request(32'hFFFF_FFFE, 32'd1);
        send_speed_request(32'hFFFF_FFFE, 32'd0);
        send_speed_request(32'hFFFF_FFF0, 32'(5 * ONE));
        wait_for_drain();

        // Largest duty scale, so any real drive saturates the duty.
        s = nominal;
        s.duty = 32'h7FFF_FFFF;
        apply_settings(s);
        send_speed_request(32'hFFFF_FFF8, 32'(100 * ONE));
        send_speed_request(32'h0000_0010, -32'(100 * ONE));
        send_speed_request(32'h0000_0010, 32'(3 * ONE));
        wait_for_drain();

        // Inverted limits: lower +10.0 above upper -10.0.
        s = nominal;
        s.upper = -32'(10 * ONE);
        s.lower = 32'(10 * ONE);
        apply_settings(s);
        send_speed_request(32'h0000_0020, 32'(30 * ONE));
        send_speed_request(32'h0000_0030, -32'(30 * ONE));
        send_speed_request(32'h0000_0030, 32'd0);
        wait_for_drain();

        // Most negative gains and scale, zero step and duty, widest limits.
        s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
        apply_settings(s);
        send_speed_request(32'h0000_0040, 32'h7FFF_FFFF);
        send_speed_request(32'hC000_0000, 32'h8000_0000);
        send_speed_request(32'h4000_0000, 32'(ONE));
        wait_for_drain();

        // Random part. Most requests follow a running encoder position with
        // small deltas and a set point that holds for a while, so the filter
        // and the integral build up; some release the motor, and a few are
        // raw noise on both fields.
        enc_count = $urandom;
        set_point = 32'(40 * ONE);
        for (int p = 0; p < RAND_PHASES; p++) begin
            apply_settings(pick_settings());
            gapless = $urandom_range(0, 3) == 0;
            if (p == 1 || $urandom_range(0, 3) == 0)
                hold_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        count     = $urandom;
                        target    = $urandom;
                        enc_count = count;
                    end
                    1: begin
                        enc_count = enc_count + $urandom_range(0, 400) - 200;
                        count     = enc_count;
                        target    = '0;
                    end
                    default: begin
                        enc_count = enc_count + $urandom_range(0, 400) - 200;
                        if ($urandom_range(0, 7) == 0)
                            set_point = $urandom_range(0, 400 * ONE) - 200 * ONE;
                        count  = enc_count;
                        target = set_point;
                    end
                endcase
                send_speed_request(count, target);
            end
            wait_for_drain();
        end

        // Anything still expected now is reported by the checker.
        final_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
